### hdl/utf8_to_utf16_decoder_defines.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_defines
// assertion macros used by the decoder top level
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// types and constants of the utf-8 to utf-16 decoder
// ----------------------------------------------------------------------------
package u2u_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic REG_ERROR_SIGNAL = 1'b0;

    localparam logic [7:0]  LEAD_MIN     = 8'hC2;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
    localparam logic [7:0]  LEAD_LIMIT   = 8'hF5;
    localparam logic [7:0]  E0_CONT_MIN  = 8'hA0;
    localparam logic [7:0]  ED_CONT_MAX  = 8'h9F;
    localparam logic [7:0]  F0_CONT_MIN  = 8'h90;
    localparam logic [7:0]  F4_CONT_MAX  = 8'h8F;
    localparam logic [20:0] SURR_POINT   = 21'h00D000;
    localparam logic [20:0] TOP_PLANE    = 21'h100000;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] BOM_POINT    = 16'hFEFF;
    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;

    typedef enum logic [1:0] {
        OP_UNIT    = 2'd0,
        OP_PAIR    = 2'd1,
        OP_REPLACE = 2'd2,
        OP_ERROR   = 2'd3
    } op_t;

    // one queued record: optional leading replacement, then the main result
    typedef struct packed {
        logic        pre_repl;
        op_t         op;
        logic [20:0] point;
    } rec_t;

endpackage

### hdl/u2u_channels.sv
// ----------------------------------------------------------------------------
// u2u channels
// valid/ready interfaces for input bytes and output code units
// ----------------------------------------------------------------------------
interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;

    modport source (output valid, output byte_req, input ready);
    modport sink (input valid, input byte_req, output ready);
endinterface

interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last;
    logic        error;

    modport source (output valid, output code_unit, output last, output error, input ready);
    modport sink (input valid, input code_unit, input last, input error, output ready);
endinterface

### hdl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// small record queue between the decode front and the unit back
// ----------------------------------------------------------------------------
module u2u_queue #(
    parameter int Depth = u2u_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u2u_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output u2u_pkg::rec_t head,
    output logic          empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    u2u_pkg::rec_t     mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### hdl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// accepts utf-8 bytes, tracks the open sequence and classifies each item
// ----------------------------------------------------------------------------
module u2u_front (
    input  logic          clk,
    input  logic          rst_n,
    u2u_byte_if.sink      byte_ch,
    input  logic          error_signal,
    input  logic          queue_full,
    output logic          push,
    output u2u_pkg::rec_t push_rec
);

    logic [20:0] pp_reg;
    logic [20:0] pp_next;
    logic [1:0]  due_reg;
    logic [1:0]  due_next;
    logic [2:0]  len_reg;
    logic [2:0]  len_next;
    logic        first_reg;
    logic        first_next;

    logic [7:0]     c;
    logic           accept;
    logic           emit;
    logic           idle_emit;
    u2u_pkg::op_t   idle_op;
    logic [20:0]    idle_pp;
    logic [1:0]     idle_due;
    logic [2:0]     idle_len;
    logic           idle_first;
    logic           is_cont;
    logic           out_of_range;
    logic [20:0]    shifted;
    logic [20:0]    merged;

    assign c             = byte_ch.byte_req;
    assign byte_ch.ready = !queue_full;
    assign accept        = byte_ch.valid && !queue_full;
    assign push          = accept && emit;

    // lead byte decode, used with no sequence open or, in replace mode, after a broken one
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_op    = u2u_pkg::OP_UNIT;
        idle_pp    = '0;
        idle_due   = 2'd0;
        idle_len   = 3'd1;
        idle_first = first_reg;
        if (!c[7])
        begin
            idle_emit  = 1'b1;
            idle_first = 1'b0;
        end
        else if (c < u2u_pkg::LEAD_MIN || c >= u2u_pkg::LEAD_LIMIT)
        begin
            idle_emit  = 1'b1;
            idle_op    = error_signal ? u2u_pkg::OP_ERROR : u2u_pkg::OP_REPLACE;
            idle_first = 1'b0;
        end
        else if (c < u2u_pkg::LEAD_THREE)
        begin
            idle_pp  = {10'b0, c[4:0], 6'b0};
            idle_due = 2'd1;
            idle_len = 3'd2;
        end
        else if (c < u2u_pkg::LEAD_FOUR)
        begin
            idle_pp  = {5'b0, c[3:0], 12'b0};
            idle_due = 2'd2;
            idle_len = 3'd3;
        end
        else
        begin
            idle_pp  = {c[2:0], 18'b0};
            idle_due = 2'd3;
            idle_len = 3'd4;
        end
    end

    assign is_cont = (c[7:6] == 2'b10);

    assign out_of_range =
        (len_reg == 3'd3 && due_reg == 2'd2 &&
         ((pp_reg == '0 && c < u2u_pkg::E0_CONT_MIN) ||
          (pp_reg == u2u_pkg::SURR_POINT && c > u2u_pkg::ED_CONT_MAX))) ||
        (due_reg == 2'd3 &&
         ((pp_reg == '0 && c < u2u_pkg::F0_CONT_MIN) ||
          (pp_reg == u2u_pkg::TOP_PLANE && c > u2u_pkg::F4_CONT_MAX)));

    always_comb
    begin
        case (due_reg)
            2'd3:    shifted = {3'b0, c[5:0], 12'b0};
            2'd2:    shifted = {9'b0, c[5:0], 6'b0};
            default: shifted = {15'b0, c[5:0]};
        endcase
    end

    assign merged = pp_reg | shifted;

    always_comb
    begin
        emit              = 1'b0;
        push_rec.pre_repl = 1'b0;
        push_rec.op       = idle_op;
        push_rec.point    = {13'b0, c};
        pp_next           = pp_reg;
        due_next          = due_reg;
        len_next          = len_reg;
        first_next        = first_reg;
        if (due_reg == 2'd0)
        begin
            emit       = idle_emit;
            pp_next    = idle_pp;
            due_next   = idle_due;
            len_next   = idle_len;
            first_next = idle_first;
        end
        else if (!is_cont || out_of_range)
        begin
            emit       = 1'b1;
            first_next = 1'b0;
            if (error_signal)
            begin
                push_rec.op = u2u_pkg::OP_ERROR;
                pp_next     = '0;
                due_next    = 2'd0;
                len_next    = 3'd1;
            end
            else
            begin
                // replacement, then the byte again as a lead byte
                push_rec.pre_repl = idle_emit;
                push_rec.op       = idle_emit ? idle_op : u2u_pkg::OP_REPLACE;
                pp_next           = idle_pp;
                due_next          = idle_due;
                len_next          = idle_len;
            end
        end
        else if (due_reg == 2'd1)
        begin
            push_rec.point = merged;
            pp_next        = '0;
            due_next       = 2'd0;
            len_next       = 3'd1;
            first_next     = 1'b0;
            if (merged[20:16] != 5'd0)
            begin
                emit        = 1'b1;
                push_rec.op = u2u_pkg::OP_PAIR;
            end
            else
            begin
                emit        = (merged[15:0] != u2u_pkg::BOM_POINT) || !first_reg;
                push_rec.op = u2u_pkg::OP_UNIT;
            end
        end
        else
        begin
            pp_next  = merged;
            due_next = due_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg    <= '0;
            due_reg   <= 2'd0;
            len_reg   <= 3'd1;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            pp_reg    <= pp_next;
            due_reg   <= due_next;
            len_reg   <= len_next;
            first_reg <= first_next;
        end
    end

endmodule

### hdl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// expands queued records into utf-16 code units, one per cycle while a record is queued and the output is ready
// ----------------------------------------------------------------------------
module u2u_back (
    input  logic          clk,
    input  logic          rst_n,
    input  u2u_pkg::rec_t head,
    input  logic          empty,
    output logic          pop,
    u2u_unit_if.source    unit_ch
);

    logic        phase_reg;
    logic        phase_next;
    logic        two_units;
    logic        take;
    logic        main_sel;
    logic [20:0] supp;
    logic [15:0] main_first;
    logic [15:0] main_second;

    assign supp      = head.point - u2u_pkg::SUPP_BASE;
    assign two_units = head.pre_repl || (head.op == u2u_pkg::OP_PAIR);
    assign main_sel  = head.pre_repl ? phase_reg : 1'b0;

    always_comb
    begin
        case (head.op)
            u2u_pkg::OP_UNIT:    main_first = head.point[15:0];
            u2u_pkg::OP_PAIR:    main_first = u2u_pkg::HIGH_SURR | {6'b0, supp[19:10]};
            u2u_pkg::OP_REPLACE: main_first = u2u_pkg::REPL_UNIT;
            default:             main_first = '0;
        endcase
    end

    assign main_second = u2u_pkg::LOW_SURR | {6'b0, supp[9:0]};

    always_comb
    begin
        unit_ch.error = 1'b0;
        if (head.pre_repl && !phase_reg)
        begin
            unit_ch.code_unit = u2u_pkg::REPL_UNIT;
        end
        else if (!main_sel && phase_reg)
        begin
            unit_ch.code_unit = main_second;
        end
        else
        begin
            unit_ch.code_unit = main_first;
            unit_ch.error     = (head.op == u2u_pkg::OP_ERROR);
        end
    end

    assign unit_ch.valid = !empty;
    assign unit_ch.last  = !two_units || phase_reg;
    assign take          = unit_ch.valid && unit_ch.ready;
    assign pop           = take && unit_ch.last;

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = !unit_ch.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

### hdl/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// utf-8 byte stream in, utf-16 code units out, with an apb control register
//
//   port      dir   item          payload
//   byte_ch   in    utf-8 byte    byte_req[7:0]
//   unit_ch   out   code unit     code_unit[15:0], last, error
//   apb       in    reg write     error_signal at byte address 0
//
// one byte is taken per cycle while the record queue has room
// a code unit is offered from the record queue, where its record is registered after its byte is taken
// a supplementary character or a replacement plus reprocessed byte gives two
// code units, offered one after the other on the single output port
// reset is asynchronous; it clears the sequence state and error_signal
// either side may stall; the queue absorbs up to QueueDepth records
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module utf8_to_utf16_decoder #(
    parameter int QueueDepth = u2u_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    u2u_byte_if.sink                       byte_ch,
    u2u_unit_if.source                     unit_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [u2u_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [u2u_pkg::APB_DATA_W-1:0] pwdata,
    output logic [u2u_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic          error_signal_reg;
    logic          error_signal_next;
    logic          reg_index;
    logic          queue_full;
    logic          queue_empty;
    logic          push;
    logic          pop;
    u2u_pkg::rec_t push_rec;
    u2u_pkg::rec_t head;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign prdata    = (reg_index == u2u_pkg::REG_ERROR_SIGNAL)
                     ? {{(u2u_pkg::APB_DATA_W - 1){1'b0}}, error_signal_reg} : '0;

    always_comb
    begin
        error_signal_next = error_signal_reg;
        if (psel && penable && pwrite && pready && reg_index == u2u_pkg::REG_ERROR_SIGNAL)
        begin
            error_signal_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_signal_reg <= 1'b0;
        end
        else
        begin
            error_signal_reg <= error_signal_next;
        end
    end

    u2u_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_ch      (byte_ch),
        .error_signal (error_signal_reg),
        .queue_full   (queue_full),
        .push         (push),
        .push_rec     (push_rec)
    );

    u2u_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    u2u_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (queue_empty),
        .pop     (pop),
        .unit_ch (unit_ch)
    );

    `U2U_ASSERT_NOW(a_error_is_last, unit_ch.valid && unit_ch.error, unit_ch.last && unit_ch.code_unit == 16'h0000, "error item must be a lone zero unit")
    `U2U_ASSERT_NOW(a_high_not_last, unit_ch.valid && unit_ch.code_unit[15:10] == 6'b110110, !unit_ch.last && !unit_ch.error, "high surrogate marked last")
    `U2U_ASSERT_NEXT(a_low_follows, unit_ch.valid && unit_ch.ready && unit_ch.code_unit[15:10] == 6'b110110, unit_ch.valid && unit_ch.code_unit[15:10] == 6'b110111 && unit_ch.last, "low surrogate does not follow high surrogate")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the utf-8 to utf-16 decoder: bytes are sent over the input
// channel with random gaps while the output side stalls at random, and each
// code unit is checked against a predictor that decodes the same byte stream
// in replace and signal mode
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
        logic        error;
    } unit_exp_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [u2u_pkg::APB_ADDR_W-1:0] paddr;
    logic [u2u_pkg::APB_DATA_W-1:0] pwdata;
    logic [u2u_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    u2u_byte_if byte_ch ();
    u2u_unit_if unit_ch ();

    utf8_to_utf16_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .unit_ch (unit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder state as the predictor sees it
    logic [20:0] point_acc;
    logic [1:0]  conts_left;
    logic [2:0]  seq_len;
    logic        at_stream_start;
    logic        err_mode;

    logic [15:0] step_unit [2];
    logic        step_err [2];
    int          step_count;

    unit_exp_t   expected_units [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          idling_on = 1'b1;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // output side: random stall bursts
    initial
    begin
        unit_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                unit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            unit_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_units
        unit_exp_t want;
        if (rst_n && unit_ch.valid && unit_ch.ready)
        begin
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected code unit, expected none, actual %h last %b error %b",
                         $time, unit_ch.code_unit, unit_ch.last, unit_ch.error);
                mismatches++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (want.code_unit !== unit_ch.code_unit || want.last !== unit_ch.last ||
                    want.error !== unit_ch.error)
                begin
                    $display("%0t: expected %h last %b error %b, actual %h last %b error %b",
                             $time, want.code_unit, want.last, want.error,
                             unit_ch.code_unit, unit_ch.last, unit_ch.error);
                    mismatches++;
                end
            end
        end
    end

    task automatic push_unit(input logic [15:0] unit, input logic err);
        step_unit[step_count] = unit;
        step_err[step_count] = err;
        step_count++;
    endtask

    task automatic clear_sequence();
        point_acc = '0;
        conts_left = '0;
        seq_len = 3'd1;
    endtask

    task automatic reject_byte();
        at_stream_start = 1'b0;
        clear_sequence();
        if (err_mode)
            push_unit(16'h0000, 1'b1);
        else
            push_unit(u2u_pkg::REPL_UNIT, 1'b0);
    endtask

    task automatic take_lead(input logic [7:0] b);
        if (b < 8'h80)
        begin
            at_stream_start = 1'b0;
            seq_len = 3'd1;
            push_unit({8'h00, b}, 1'b0);
        end
        else if (b < u2u_pkg::LEAD_MIN || b >= u2u_pkg::LEAD_LIMIT)
            reject_byte();
        else if (b < u2u_pkg::LEAD_THREE)
        begin
            point_acc = {10'b0, b[4:0], 6'b0};
            conts_left = 2'd1;
            seq_len = 3'd2;
        end
        else if (b < u2u_pkg::LEAD_FOUR)
        begin
            point_acc = {5'b0, b[3:0], 12'b0};
            conts_left = 2'd2;
            seq_len = 3'd3;
        end
        else
        begin
            point_acc = {b[2:0], 18'b0};
            conts_left = 2'd3;
            seq_len = 3'd4;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic        is_cont;
        logic        off_range;
        logic [20:0] offset;
        unit_exp_t   rec;
        int          sh;
        step_count = 0;
        if (conts_left == 2'd0)
            take_lead(b);
        else
        begin
            is_cont = (b[7:6] == 2'b10);
            off_range = (seq_len == 3'd3 && conts_left == 2'd2 &&
                         ((point_acc == 21'd0 && b < u2u_pkg::E0_CONT_MIN) ||
                          (point_acc == u2u_pkg::SURR_POINT && b > u2u_pkg::ED_CONT_MAX))) ||
                        (conts_left == 2'd3 &&
                         ((point_acc == 21'd0 && b < u2u_pkg::F0_CONT_MIN) ||
                          (point_acc == u2u_pkg::TOP_PLANE && b > u2u_pkg::F4_CONT_MAX)));
            if (!is_cont || off_range)
            begin
                reject_byte();
                if (!err_mode)
                    take_lead(b);
            end
            else
            begin
                sh = 6 * (conts_left - 1);
                point_acc = point_acc | ({15'b0, b[5:0]} << sh);
                conts_left = conts_left - 2'd1;
                if (conts_left == 2'd0)
                begin
                    if (point_acc > 21'h00FFFF)
                    begin
                        offset = point_acc - u2u_pkg::SUPP_BASE;
                        push_unit(u2u_pkg::HIGH_SURR | {6'b0, offset[19:10]}, 1'b0);
                        push_unit(u2u_pkg::LOW_SURR | {6'b0, offset[9:0]}, 1'b0);
                    end
                    else if (point_acc[15:0] != u2u_pkg::BOM_POINT || !at_stream_start)
                        push_unit(point_acc[15:0], 1'b0);
                    clear_sequence();
                    at_stream_start = 1'b0;
                end
            end
        end
        for (int i = 0; i < step_count; i++)
        begin
            rec.code_unit = step_unit[i];
            rec.last = (i == step_count - 1);
            rec.error = step_err[i];
            expected_units.push_back(rec);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.byte_req <= b;
        do @(posedge clk); while (!byte_ch.ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_units.size() != 0) @(posedge clk);
        repeat (u2u_pkg::QUEUE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic set_error_signal(input logic value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {u2u_pkg::REG_ERROR_SIGNAL, 2'b00};
        pwdata <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        err_mode = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_random_char();
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 19);
        lo = 8'h80;
        hi = 8'hBF;
        if (r < 4)
            send_byte(8'($urandom_range(0, 127)));
        else if (r < 8)
        begin
            send_byte(8'($urandom_range(u2u_pkg::LEAD_MIN, 8'hDF)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r < 12)
        begin
            lead = 8'($urandom_range(u2u_pkg::LEAD_THREE, 8'hEF));
            if ($urandom_range(0, 3) != 0)
            begin
                if (lead == u2u_pkg::LEAD_THREE)
                    lo = u2u_pkg::E0_CONT_MIN;
                if (lead == 8'hED)
                    hi = u2u_pkg::ED_CONT_MAX;
            end
            send_byte(lead);
            send_byte(8'($urandom_range(lo, hi)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r < 15)
        begin
            lead = 8'($urandom_range(u2u_pkg::LEAD_FOUR, u2u_pkg::LEAD_LIMIT - 8'd1));
            if ($urandom_range(0, 3) != 0)
            begin
                if (lead == u2u_pkg::LEAD_FOUR)
                    lo = u2u_pkg::F0_CONT_MIN;
                if (lead == u2u_pkg::LEAD_LIMIT - 8'd1)
                    hi = u2u_pkg::F4_CONT_MAX;
            end
            send_byte(lead);
            send_byte(8'($urandom_range(lo, hi)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
            send_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r == 15)
        begin
            send_byte(8'hEF);
            send_byte(8'hBB);
            send_byte(8'hBF);
        end
        else if (r < 18)
            send_byte(8'($urandom_range(0, 255)));
        else
        begin
            // lead followed by a non-continuation, or cut short by ascii
            send_byte(8'($urandom_range(u2u_pkg::LEAD_MIN, u2u_pkg::LEAD_LIMIT - 8'd1)));
            if (r == 19)
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            b = 8'($urandom_range(0, 191));
            if (r == 19)
                b = b & 8'h7F;
            else if (b >= 8'h80)
                b = b + 8'd64;
            send_byte(b);
        end
    endtask

    task automatic test_byte_order_mark();
        // dropped only as the first character of the stream
        send_byte(8'hEF);
        send_byte(8'hBB);
        send_byte(8'hBF);
        send_byte(8'hEF);
        send_byte(8'hBB);
        send_byte(8'hBF);
    endtask

    task automatic test_lead_extremes();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'hC1);
        send_byte(8'hF5);
    endtask

    task automatic test_continuation_range();
        // overlong, surrogate and above-range first continuations, then the highest valid four-byte sequence
        send_byte(u2u_pkg::LEAD_THREE);
        send_byte(8'h9F);
        send_byte(8'hED);
        send_byte(8'hA0);
        send_byte(u2u_pkg::LEAD_FOUR);
        send_byte(8'h8F);
        send_byte(u2u_pkg::LEAD_LIMIT - 8'd1);
        send_byte(8'h90);
        send_byte(u2u_pkg::LEAD_LIMIT - 8'd1);
        send_byte(8'h8F);
        send_byte(8'hBF);
        send_byte(8'hBF);
    endtask

    task automatic test_signal_errors();
        set_error_signal(1'b1);
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'h80);
    endtask

    task automatic test_random_mix(input logic mode, input int count, input bit pause_midway);
        int  start;
        bit  paused;
        set_error_signal(mode);
        start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < count)
        begin
            if (pause_midway && !paused && bytes_sent - start >= count / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_char();
        end
    endtask

    task automatic test_quiet_tail();
        wait_drained();
        idling_on = 1'b0;
        test_random_mix(1'b0, 100, 1'b0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.byte_req <= 8'h00;
        err_mode = 1'b0;
        at_stream_start = 1'b1;
        clear_sequence();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_error_signal(1'b0);
        test_byte_order_mark();
        test_lead_extremes();
        test_continuation_range();
        test_signal_errors();
        test_random_mix(1'b0, 150, 1'b1);
        test_random_mix(1'b1, 150, 1'b0);
        test_quiet_tail();

        wait_drained();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
